// ----- sv/ssort_pkg.sv -----
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared types and constants for the stack sort block.
// ----------------------------------------------------------------------------
package ssort_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // loading values onto the main stack
    S_OUTER = 7'b0000010,  // pop the main stack or finish the sort
    S_POPW  = 7'b0000100,  // main read data arrives, latch current value
    S_INRD  = 7'b0001000,  // read the aux top or push current value
    S_INCMP = 7'b0010000,  // compare aux top against current value
    S_EMRD  = 7'b0100000,  // read next result from the aux stack
    S_EMLD  = 7'b1000000   // load result into the output register
  } state_t;

endpackage

// ----- sv/stack_sort_with_aux_stack.sv -----
// ----------------------------------------------------------------------------
// stack_sort_with_aux_stack
// Collects signed values on a main stack and, on the last value of a set,
// sorts them with an auxiliary stack and streams them out smallest first.
// ----------------------------------------------------------------------------
//   channel | direction | tdata          | tlast     | tuser
//   in_     | request   | value          | last      | -
//   out_    | result    | sorted_value   | last_res  | overflow
//
// Loading takes one value per cycle. Sorting pops each value and compares it
// with the aux top; larger aux entries go back to the main stack to be popped
// again, then the value is pushed. Emission reads each result from the aux
// stack, then loads the output register. Both stacks are synchronous memories
// with registered read data. Reset clears counts, sequencer, overflow flag and
// out valid. Input is taken only while loading; out_tready low stalls emission.
// ----------------------------------------------------------------------------
module stack_sort_with_aux_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ssort_pkg::DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                          in_tlast,   // last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ssort_pkg::DATA_W-1:0]  out_tdata,  // [31:0] sorted_value
  output logic                          out_tlast,  // last_res
  output logic                          out_tuser   // [0] overflow
);
  import ssort_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   main_cnt_r, main_cnt_nxt;
  logic [CW-1:0]   aux_cnt_r, aux_cnt_nxt;
  logic [AW-1:0]   emit_idx_r, emit_idx_nxt;
  logic            dropped_r, dropped_nxt;
  data_t           cur_r, cur_nxt;

  logic            out_valid_r, out_valid_nxt;
  data_t           out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            main_we, main_re, aux_we, aux_re;
  logic [AW-1:0]   main_waddr, main_raddr, aux_waddr, aux_raddr;
  data_t           main_wdata, aux_wdata, main_rdata, aux_rdata;

  logic [CW-1:0]   main_dec, aux_dec;
  logic            in_req, emit_last, out_free;

  assign main_dec  = main_cnt_r - CW'(1);
  assign aux_dec   = aux_cnt_r - CW'(1);
  assign in_req    = in_tvalid && in_tready;
  assign emit_last = (CW'(emit_idx_r) + CW'(1)) == aux_cnt_r;
  assign out_free  = !out_valid_r || out_tready;

  ssort_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .re    (main_re),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  ssort_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_aux_ram (
    .clk   (clk),
    .we    (aux_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .re    (aux_re),
    .raddr (aux_raddr),
    .rdata (aux_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    main_cnt_nxt  = main_cnt_r;
    aux_cnt_nxt   = aux_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    dropped_nxt   = dropped_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    main_we    = 1'b0;
    main_waddr = main_cnt_r[AW-1:0];
    main_wdata = data_t'(in_tdata);
    main_re    = 1'b0;
    main_raddr = main_dec[AW-1:0];
    aux_we     = 1'b0;
    aux_waddr  = aux_cnt_r[AW-1:0];
    aux_wdata  = cur_r;
    aux_re     = 1'b0;
    aux_raddr  = aux_dec[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_req) begin
          if (main_cnt_r < CW'(STACK_DEPTH)) begin
            main_we      = 1'b1;
            main_cnt_nxt = main_cnt_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_OUTER;
          end
        end
      end
      S_OUTER: begin
        if (main_cnt_r == '0) begin
          emit_idx_nxt = '0;
          state_nxt    = S_EMRD;
        end else begin
          main_re      = 1'b1;
          main_cnt_nxt = main_dec;
          state_nxt    = S_POPW;
        end
      end
      S_POPW: begin
        cur_nxt   = main_rdata;
        state_nxt = S_INRD;
      end
      S_INRD: begin
        if (aux_cnt_r == '0) begin
          aux_we      = 1'b1;
          aux_cnt_nxt = aux_cnt_r + CW'(1);
          state_nxt   = S_OUTER;
        end else begin
          aux_re    = 1'b1;
          state_nxt = S_INCMP;
        end
      end
      S_INCMP: begin
        if (aux_rdata > cur_r) begin
          // larger aux top goes back onto the main stack
          main_we      = 1'b1;
          main_wdata   = aux_rdata;
          main_cnt_nxt = main_cnt_r + CW'(1);
          aux_cnt_nxt  = aux_dec;
          state_nxt    = S_INRD;
        end else begin
          aux_we      = 1'b1;
          aux_cnt_nxt = aux_cnt_r + CW'(1);
          state_nxt   = S_OUTER;
        end
      end
      S_EMRD: begin
        // aux stack is ascending from the bottom
        aux_re    = 1'b1;
        aux_raddr = emit_idx_r;
        state_nxt = S_EMLD;
      end
      S_EMLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = aux_rdata;
          out_last_nxt  = emit_last;
          out_ovf_nxt   = dropped_r;
          if (emit_last) begin
            aux_cnt_nxt  = '0;
            main_cnt_nxt = '0;
            dropped_nxt  = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + AW'(1);
            state_nxt    = S_EMRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      main_cnt_r  <= '0;
      aux_cnt_r   <= '0;
      emit_idx_r  <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      main_cnt_r  <= main_cnt_nxt;
      aux_cnt_r   <= aux_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ----- sv/ssort_ram.sv -----
// ----------------------------------------------------------------------------
// ssort_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module ssort_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  ssort_pkg::data_t      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output ssort_pkg::data_t      rdata
);
  import ssort_pkg::*;

  data_t mem [DEPTH];
  data_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
